// File: design/bwsp_pkg.sv
`default_nettype none
package bwsp_pkg;
  localparam int MaxGates = 64;
  localparam int NumQubits = 64;
  localparam int IdxW = $clog2(MaxGates);
  localparam int CntW = $clog2(MaxGates + 1);
  localparam int CfgW = 7;
  localparam int PopW = 7;
  localparam int ScW = CntW;

  typedef logic [NumQubits-1:0] mask_t;
  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic pass_init;
    logic start_init;
    logic next_start;
    logic step;
    logic mem_rd;
    logic commit;
    logic emit_init;
    logic emit_adv;
  } bwsp_cmd_t;

  typedef struct packed {
    logic start_skip;
    logic window_done;
    logic pass_done;
    logic found;
    logic commit_done;
    logic emit_done;
    logic emit_hit;
    logic any_region;
    logic emit_last;
  } bwsp_sts_t;

  function automatic logic [PopW-1:0] popcount(input mask_t v);
    logic [PopW-1:0] c;
    c = '0;
    for (int i = 0; i < NumQubits; i++) c = c + PopW'(v[i]);
    return c;
  endfunction
endpackage
`default_nettype wire

// File: design/bwsp_datapath.sv
`default_nettype none
module bwsp_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire bwsp_pkg::bwsp_cmd_t cmd,
  output bwsp_pkg::bwsp_sts_t sts,
  input  wire logic [63:0] gate_qubits,
  input  wire logic [6:0] size_cfg,
  output logic [5:0] emit_start,
  output logic [5:0] emit_end
);
  import bwsp_pkg::*;

  mask_t mem [MaxGates];
  mask_t rd_data;
  logic [MaxGates-1:0] used;
  logic [MaxGates-1:0] has_region;
  idx_t region_end [MaxGates];
  idx_t rd_end;
  cnt_t gate_count;
  cnt_t s_ptr, e_ptr, best_s, best_e, emit_ptr, c_ptr, last_s;
  mask_t uni;
  logic [ScW-1:0] sc;
  logic [ScW:0] best;
  logic found, any_region, stopped;
  logic [CfgW-1:0] limit;
  mask_t uni_next;
  logic [PopW-1:0] pc_u, pc_g;
  logic fits;

  assign limit = (size_cfg < CfgW'(2)) ? CfgW'(2) : size_cfg;
  assign uni_next = uni | rd_data;

  // single popcount per path, data registered from memory
  assign pc_u = popcount(uni_next);
  assign pc_g = popcount(rd_data);
  assign fits = !used[e_ptr[IdxW-1:0]] && (pc_u <= limit);

  always_ff @(posedge clk) begin
    if (cmd.load && gate_count < cnt_t'(MaxGates)) mem[gate_count[IdxW-1:0]] <= gate_qubits;
    if (cmd.mem_rd) rd_data <= mem[e_ptr[IdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && c_ptr == best_s) region_end[best_s[IdxW-1:0]] <= best_e[IdxW-1:0];
    rd_end <= region_end[emit_ptr[IdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      gate_count <= '0;
      used <= '0;
      has_region <= '0;
      any_region <= 1'b0;
    end else begin
      if (cmd.load && gate_count < cnt_t'(MaxGates)) gate_count <= gate_count + cnt_t'(1);
      if (cmd.commit) begin
        used[c_ptr[IdxW-1:0]] <= 1'b1;
        if (c_ptr == best_s) begin
          has_region[best_s[IdxW-1:0]] <= 1'b1;
          any_region <= 1'b1;
          if (!any_region || best_s > last_s) last_s <= best_s;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pass_init) begin
      s_ptr <= '0;
      best <= '1;
      found <= 1'b0;
    end else if (cmd.next_start) begin
      s_ptr <= s_ptr + cnt_t'(1);
    end
    if (cmd.start_init) begin
      e_ptr <= s_ptr;
      uni <= '0;
      sc <= '0;
      stopped <= 1'b0;
    end
    if (cmd.step) begin
      if (!stopped && fits) begin
        uni <= uni_next;
        if ((pc_g >= PopW'(2)) &&
            (best[ScW] || ({1'b0, sc + ScW'(1)} > best))) begin
          best <= {1'b0, sc + ScW'(1)};
          best_s <= s_ptr;
          best_e <= e_ptr;
          found <= 1'b1;
        end else if (!(pc_g >= PopW'(2)) && (best[ScW] || ({1'b0, sc} > best))) begin
          best <= {1'b0, sc};
          best_s <= s_ptr;
          best_e <= e_ptr;
          found <= 1'b1;
        end
        if (pc_g >= PopW'(2)) sc <= sc + ScW'(1);
        e_ptr <= e_ptr + cnt_t'(1);
      end else begin
        stopped <= 1'b1;
      end
    end
    if (rst || cmd.emit_init) emit_ptr <= '0;
    else if (cmd.emit_adv) emit_ptr <= emit_ptr + cnt_t'(1);
    if (cmd.commit) c_ptr <= c_ptr + cnt_t'(1);
    else c_ptr <= best_s;
  end

  assign sts.start_skip = used[s_ptr[IdxW-1:0]];
  assign sts.window_done = stopped || (e_ptr >= gate_count);
  assign sts.pass_done = s_ptr >= gate_count;
  assign sts.found = found;
  assign sts.commit_done = c_ptr >= best_e;
  assign sts.emit_done = emit_ptr >= gate_count;
  assign sts.emit_hit = has_region[emit_ptr[IdxW-1:0]];
  assign sts.any_region = any_region;
  assign sts.emit_last = emit_ptr == last_s;
  assign emit_start = emit_ptr[5:0];
  assign emit_end = rd_end;
endmodule
`default_nettype wire

// File: design/bwsp_ctrl.sv
`default_nettype none
module bwsp_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic last_gate,
  output logic out_valid,
  input  wire logic out_ready,
  output logic out_last,
  output logic out_none,
  output bwsp_pkg::bwsp_cmd_t cmd,
  input  wire bwsp_pkg::bwsp_sts_t sts
);
  import bwsp_pkg::*;

  typedef enum logic [9:0] {
    LOAD   = 10'b0000000001,
    PASS   = 10'b0000000010,
    RD     = 10'b0000000100,
    STEP   = 10'b0000001000,
    NEXTS  = 10'b0000010000,
    COMMIT = 10'b0000100000,
    ESCAN  = 10'b0001000000,
    EOUT   = 10'b0010000000,
    ENONE  = 10'b0100000000,
    CLR    = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= LOAD;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    out_last = 1'b0;
    out_none = 1'b0;
    case (state)
      LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (last_gate) state_next = PASS;
        end
      end
      PASS: begin
        cmd.pass_init = 1'b1;
        state_next = NEXTS;
      end
      NEXTS: begin
        if (sts.pass_done) state_next = sts.found ? COMMIT : ESCAN;
        else if (sts.start_skip) cmd.next_start = 1'b1;
        else begin
          cmd.start_init = 1'b1;
          state_next = RD;
        end
      end
      RD: begin
        cmd.mem_rd = 1'b1;
        if (sts.window_done) begin
          cmd.next_start = 1'b1;
          state_next = NEXTS;
        end else begin
          state_next = STEP;
        end
      end
      STEP: begin
        cmd.step = 1'b1;
        state_next = RD;
      end
      COMMIT: begin
        cmd.commit = 1'b1;
        if (sts.commit_done) state_next = PASS;
      end
      ESCAN: begin
        if (sts.emit_hit && !sts.emit_done) state_next = EOUT;
        else if (sts.emit_done) state_next = sts.any_region ? CLR : ENONE;
        else cmd.emit_adv = 1'b1;
      end
      EOUT: begin
        out_valid = 1'b1;
        out_last = sts.emit_last;
        if (out_ready) begin
          cmd.emit_adv = 1'b1;
          state_next = ESCAN;
        end
      end
      ENONE: begin
        out_valid = 1'b1;
        out_last = 1'b1;
        out_none = 1'b1;
        if (out_ready) state_next = CLR;
      end
      CLR: begin
        cmd.clear = 1'b1;
        cmd.emit_init = 1'b1;
        state_next = LOAD;
      end
      default: state_next = LOAD;
    endcase
  end

  a_one: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not onehot");
  a_noin: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("load during emit");
  a_cmt: assert property (@(posedge clk) disable iff (rst) cmd.commit |-> sts.found)
    else $error("commit without window");
endmodule
`default_nettype wire

// File: design/best_window_span_partition.sv
`default_nettype none
// best_window_span_partition
// input channel: gate_qubits and last_gate, valid/ready; one gate per cycle
// while loading. last_gate ends the circuit and starts the search.
// search: a pass starts in PASS and tries each start index in NEXTS; a
// window alternates a read (RD) and a step (STEP) per gate tried and closes
// with a read, as the mask memory has a single read port; the winner's gates
// are marked used in COMMIT, and passes repeat until no window fits.
// output channel: region_start, region_end, last_region, no_region,
// valid/ready, in order of start. the region list is scanned one index a cycle
// while no region waits for the receiver; a clear state (CLR) follows the scan.
// no gate is taken during search or emission.
// a stalled receiver holds the current region until taken.
// the region size is to be written through cfg_we/cfg_data only while idle; the block does not enforce it.
// reset (rst, synchronous) empties the gate list and sets the region size to 4.
module best_window_span_partition (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [63:0] gate_qubits,
  input  wire logic last_gate,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [5:0] region_start,
  output logic [5:0] region_end,
  output logic last_region,
  output logic no_region,
  input  wire logic cfg_we,
  input  wire logic [6:0] cfg_data
);
  import bwsp_pkg::*;

  bwsp_cmd_t cmd;
  bwsp_sts_t sts;
  logic [6:0] size_cfg;
  logic [5:0] es, ee;
  logic olast, onone;

  always_ff @(posedge clk) begin
    if (rst) size_cfg <= 7'd4;
    else if (cfg_we) size_cfg <= cfg_data;
  end

  bwsp_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .last_gate, .out_valid, .out_ready,
    .out_last(olast), .out_none(onone), .cmd, .sts
  );

  bwsp_datapath u_dp (
    .clk, .rst, .cmd, .sts, .gate_qubits, .size_cfg,
    .emit_start(es), .emit_end(ee)
  );

  assign region_start = onone ? 6'd0 : es;
  assign region_end = onone ? 6'd0 : ee;
  assign last_region = olast;
  assign no_region = onone;
endmodule
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import bwsp_pkg::*;

  typedef struct packed {
    logic [63:0] qubits;
    logic        last;
  } gate_req_t;

  typedef struct packed {
    logic [5:0] rstart;
    logic [5:0] rend;
    logic       rlast;
    logic       rnone;
  } region_t;

  localparam int WatchLimit = 400000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [63:0] gate_qubits = '0;
  logic last_gate = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [5:0] region_start;
  logic [5:0] region_end;
  logic last_region;
  logic no_region;
  logic cfg_we = 0;
  logic [6:0] cfg_data = '0;

  best_window_span_partition dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .gate_qubits(gate_qubits), .last_gate(last_gate),
    .out_valid(out_valid), .out_ready(out_ready),
    .region_start(region_start), .region_end(region_end),
    .last_region(last_region), .no_region(no_region),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  gate_req_t pending_gates[$];
  region_t   expected_regions[$];

  // partitioner shadow state
  logic [63:0] circ_mask[MaxGates];
  bit          circ_used[MaxGates];
  int          circ_end_at[MaxGates];
  int          circ_len = 0;
  int          region_limit = 4;

  int snd_idle = 0;
  int rcv_idle = 0;
  int hold_cycles = 0;
  int mismatches = 0;
  int gates_sent = 0;
  int circuits_done = 0;
  int regions_seen = 0;
  int quiet_cycles = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic run_partition();
    int lim, best, bs, be, sc;
    logic [63:0] u;
    bit found;
    region_t r;
    lim = (region_limit < 2) ? 2 : region_limit;
    for (int i = 0; i < MaxGates; i++) begin
      circ_used[i] = 0;
      circ_end_at[i] = -1;
    end
    forever begin
      best = -1; bs = 0; be = 0; found = 0;
      for (int s = 0; s < circ_len; s++) begin
        if (circ_used[s]) continue;
        u = '0; sc = 0;
        for (int e = s; e < circ_len; e++) begin
          if (circ_used[e]) break;
          u = u | circ_mask[e];
          if ($countones(u) > lim) break;
          if ($countones(circ_mask[e]) >= 2) sc++;
          if (sc > best) begin
            best = sc; bs = s; be = e; found = 1;
          end
        end
      end
      if (!found) break;
      for (int i = bs; i <= be; i++) circ_used[i] = 1;
      circ_end_at[bs] = be;
    end
    found = 0;
    for (int i = 0; i < circ_len; i++) begin
      if (circ_end_at[i] < 0) continue;
      if (found) expected_regions = {expected_regions, r};
      r.rstart = 6'(i);
      r.rend = 6'(circ_end_at[i]);
      r.rlast = 0;
      r.rnone = 0;
      found = 1;
    end
    if (!found) begin
      r = '{rstart: 6'd0, rend: 6'd0, rlast: 1'b1, rnone: 1'b1};
    end else begin
      r.rlast = 1;
    end
    expected_regions = {expected_regions, r};
    circ_len = 0;
    circuits_done++;
  endtask

  task automatic take_gate(input gate_req_t g);
    if (circ_len < MaxGates) begin
      circ_mask[circ_len] = g.qubits;
      circ_len++;
    end
    gates_sent++;
    if (g.last) run_partition();
  endtask

  // driver
  always @(posedge clk) begin
    gate_req_t g;
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) take_gate('{qubits: gate_qubits, last: last_gate});
      if (pending_gates.size() > 0 && $urandom_range(99) >= snd_idle) begin
        g = pending_gates.pop_front();
        in_valid <= 1;
        gate_qubits <= g.qubits;
        last_gate <= g.last;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // long receiver hold
  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // monitor
  always @(posedge clk) begin
    region_t e;
    bit bad;
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        regions_seen++;
        if (expected_regions.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected region start=%0d end=%0d last=%0b none=%0b",
                     region_start, region_end, last_region, no_region);
        end else begin
          e = expected_regions.pop_front();
          bad = (last_region !== e.rlast) || (no_region !== e.rnone);
          if (!e.rnone && (region_start !== e.rstart || region_end !== e.rend)) bad = 1;
          if (bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display("region mismatch exp %0d..%0d l%0b n%0b got %0d..%0d l%0b n%0b",
                       e.rstart, e.rend, e.rlast, e.rnone,
                       region_start, region_end, last_region, no_region);
          end
        end
      end
      if (hold_cycles > 0) begin
        out_ready <= 0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("best_window_span_partition verification failed");
      $finish;
    end
  end

  function automatic logic [63:0] narrow_mask();
    logic [63:0] m;
    int base;
    m = '0;
    base = $urandom_range(60);
    repeat ($urandom_range(3)) m[base + $urandom_range(3)] = 1'b1;
    return m;
  endfunction

  function automatic logic [63:0] any_mask();
    case ($urandom_range(9))
      0: return {$urandom, $urandom};
      1: return '0;
      2: return '1;
      default: return narrow_mask();
    endcase
  endfunction

  task automatic add_gate(input logic [63:0] m, input logic l);
    gate_req_t g;
    g.qubits = m;
    g.last = l;
    pending_gates = {pending_gates, g};
  endtask

  task automatic add_circuit(input int n);
    for (int i = 0; i < n; i++) add_gate(any_mask(), i == n - 1);
  endtask

  task automatic wait_drained();
    while (pending_gates.size() > 0 || in_valid || expected_regions.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_block_size(input int v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_data <= 7'(v);
    region_limit = v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    int sizes[8] = '{0, 1, 2, 64, 3, 5, 8, 4};
    int cnt;
    repeat (4) @(posedge clk);
    rst <= 0;
    // directed: singles, extremes, wide and empty gates, overflow
    add_gate(64'h1, 1);
    add_gate('1, 1);
    add_gate('0, 1);
    add_gate(64'h3, 0); add_gate(64'h6, 0); add_gate(64'h8000_0000_0000_0000, 0);
    add_gate(64'hC000_0000_0000_0000, 1);
    add_gate(64'h5, 0); add_gate('1, 0); add_gate(64'h5, 0); add_gate(64'hA, 1);
    for (int i = 0; i < 70; i++) add_gate({$urandom, $urandom}, i == 69);
    for (int i = 0; i < 64; i++) add_gate(64'h1 << $urandom_range(2), i == 63);
    wait_drained();
    for (int p = 0; p < 8; p++) begin
      write_block_size(sizes[p]);
      snd_idle = (p % 4 == 1) ? 74 : (p % 4 == 3) ? 25 : 0;
      rcv_idle = (p % 4 == 2) ? 74 : (p % 4 == 3) ? 25 : 0;
      cnt = 0;
      while (cnt < 25) begin
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        add_circuit(n);
        cnt += n;
      end
      if (p == 4) hold_cycles = 600;
      wait_drained();
    end
    $display("%0d gates in %0d circuits, %0d regions checked, block sizes 0..64",
             gates_sent, circuits_done, regions_seen);
    if (mismatches == 0 && expected_regions.size() == 0) begin
      $display("best_window_span_partition verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("best_window_span_partition verification failed");
    end
    $finish;
  end
endmodule
